/* rtl/core/lnfp_pkg.sv */
// ----------------------------------------------------------------------------
// lnfp_pkg
// shared types, constants and helpers for the lcd nibble framer and number
// printer
// ----------------------------------------------------------------------------
package lnfp_pkg;

  // width of the number taken from the request for the print ops
  localparam int VALUE_WIDTH = 32;

  // digit store: enough for ten decimal digits of a 32-bit number
  localparam int DIGIT_DEPTH = 16;
  localparam int DIGIT_AW    = $clog2(DIGIT_DEPTH);

  // register indexes of the configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BACKLIGHT_ON   = 2'd1;

  localparam logic [7:0] DEVICE_ADDRESS_RST = 8'd78;
  localparam logic       BACKLIGHT_ON_RST   = 1'b1;

  // request op codes
  typedef enum logic [2:0] {
    OP_COMMAND   = 3'd0,
    OP_DATA      = 3'd1,
    OP_CURSOR    = 3'd2,
    OP_PRINT_DEC = 3'd3,
    OP_PRINT_HEX = 3'd4
  } op_t;

  // expander byte control bits
  localparam logic [7:0] EXP_E  = 8'h04;
  localparam logic [7:0] EXP_BL = 8'h08;
  localparam logic [7:0] EXP_RS = 8'h01;

  localparam logic [7:0] CURSOR_CMD = 8'h80;

  // x / 10 == (x * RECIP_10) >> RECIP_SHIFT for every 32-bit x
  localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  // one character or command handed to the framer
  typedef struct packed {
    logic [7:0] ch;
    logic       rs;
    logic       last;
  } char_req_t;

  function automatic logic [7:0] digit_to_ascii(input logic [3:0] d);
    logic [7:0] ext;
    ext = {4'h0, d};
    if (d < 4'd10) begin
      digit_to_ascii = ext + 8'h30;
    end else begin
      digit_to_ascii = ext + 8'h37;
    end
  endfunction

endpackage

/* rtl/core/lnfp_div_unit.sv */
// ----------------------------------------------------------------------------
// lnfp_div_unit
// shared digit unit: splits a number into its lowest digit and the quotient,
// base 10 through a reciprocal multiply, base 16 through a shift
// ----------------------------------------------------------------------------
module lnfp_div_unit (
  input  logic        clk,
  input  logic        hex,
  input  logic [31:0] num,
  output logic [31:0] quot,
  output logic [3:0]  digit
);

  logic [63:0] prod_r;
  logic [31:0] num_r;
  logic        hex_r;
  logic [31:0] times_ten;

  // operands are taken every cycle, result is valid in the cycle after
  always_ff @(posedge clk) begin
    prod_r <= 64'(num) * 64'(lnfp_pkg::RECIP_10);
    num_r  <= num;
    hex_r  <= hex;
  end

  always_comb begin
    if (hex_r) begin
      quot = {4'h0, num_r[31:4]};
    end else begin
      quot = 32'(prod_r[63:lnfp_pkg::RECIP_SHIFT]);
    end
    times_ten = (quot << 3) + (quot << 1);
    if (hex_r) begin
      digit = num_r[3:0];
    end else begin
      digit = 4'(num_r - times_ten);
    end
  end

endmodule

/* rtl/core/lnfp_framer.sv */
// ----------------------------------------------------------------------------
// lnfp_framer
// turns one character or command into a five-byte expander transaction:
// address, high nibble with and without E, low nibble with and without E
// ----------------------------------------------------------------------------
module lnfp_framer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [7:0]            device_address,
  input  logic                  backlight_on,
  input  logic                  ch_valid,
  output logic                  ch_ready,
  input  lnfp_pkg::char_req_t   ch_req,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic                  out_is_address,
  output logic                  out_last
);

  typedef enum logic [2:0] {
    PH_ADDR,
    PH_HI_E,
    PH_HI,
    PH_LO_E,
    PH_LO
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic                busy_r, busy_nxt;
  lnfp_pkg::char_req_t req_r, req_nxt;
  logic                take;
  logic                done;
  logic [7:0]          ctl;
  logic [7:0]          hi;
  logic [7:0]          lo;

  // last byte leaving lets the next character in on the same edge
  assign done     = busy_r && (phase_r == PH_LO) && out_ready;
  assign ch_ready = !busy_r || done;
  assign take     = ch_valid && ch_ready;

  always_comb begin
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    req_nxt   = req_r;
    if (take) begin
      busy_nxt  = 1'b1;
      phase_nxt = PH_ADDR;
      req_nxt   = ch_req;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (busy_r && out_ready) begin
      case (phase_r)
        PH_ADDR: phase_nxt = PH_HI_E;
        PH_HI_E: phase_nxt = PH_HI;
        PH_HI:   phase_nxt = PH_LO_E;
        PH_LO_E: phase_nxt = PH_LO;
        default: phase_nxt = PH_ADDR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= PH_ADDR;
    end else begin
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
    end
    req_r <= req_nxt;
  end

  always_comb begin
    ctl = (backlight_on ? lnfp_pkg::EXP_BL : 8'h00) |
          (req_r.rs ? lnfp_pkg::EXP_RS : 8'h00);
    hi  = {req_r.ch[7:4], 4'h0};
    lo  = {req_r.ch[3:0], 4'h0};
    out_is_address = 1'b0;
    out_last       = 1'b0;
    case (phase_r)
      PH_ADDR: begin
        out_byte       = device_address;
        out_is_address = 1'b1;
      end
      PH_HI_E: out_byte = hi | ctl | lnfp_pkg::EXP_E;
      PH_HI:   out_byte = hi | ctl;
      PH_LO_E: out_byte = lo | ctl | lnfp_pkg::EXP_E;
      PH_LO: begin
        out_byte = lo | ctl;
        out_last = req_r.last;
      end
      default: out_byte = device_address;
    endcase
  end

  assign out_valid = busy_r;

endmodule

/* rtl/core/lcd_nibble_framer_number_printer_core.sv */
// ----------------------------------------------------------------------------
// lcd_nibble_framer_number_printer_core
// lcd requests to expander bytes: commands, characters, cursor moves and
// unsigned numbers printed in decimal or upper-case hex
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, in_op, in_value       | request in
//  out     | out_valid, out_ready, out_byte,           | bytes out
//          | out_is_address, out_last                  |
//  cfg     | cfg_we, cfg_index, cfg_wdata              | write only
//
// a command, character or cursor move frees the input once the framer takes it;
// its 5 bytes leave one per cycle while out_ready is high.
// a print runs each digit through the shared divide unit (S_DIV, S_DIGIT),
// then reads the digits back highest first and sends 5 bytes per digit.
// reset restores device_address 78 and backlight on; no clearing pass.
// out_ready low holds the current byte and stalls the whole sequence.
// ----------------------------------------------------------------------------
module lcd_nibble_framer_number_printer_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0]                        in_op,
  input  logic [31:0]                       in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_byte,
  output logic                              out_is_address,
  output logic                              out_last,
  input  logic                              cfg_we,
  input  logic [lnfp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [7:0]                        cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHAR,
    S_DIV,
    S_DIGIT,
    S_RD,
    S_SEND
  } state_t;

  state_t                             state_r, state_nxt;
  logic [7:0]                         device_address_r;
  logic                               backlight_on_r;
  logic [7:0]                         ch_r, ch_nxt;
  logic                               rs_r, rs_nxt;
  logic                               hex_r, hex_nxt;
  logic [lnfp_pkg::VALUE_WIDTH-1:0]   num_r, num_nxt;
  logic [lnfp_pkg::DIGIT_AW-1:0]      cnt_r, cnt_nxt;
  logic [lnfp_pkg::DIGIT_AW-1:0]      idx_r, idx_nxt;
  logic [3:0]                         digit_r;
  logic [3:0]                         digit_mem [lnfp_pkg::DIGIT_DEPTH];

  logic [31:0]                        quot;
  logic [3:0]                         digit;
  logic [lnfp_pkg::VALUE_WIDTH-1:0]   quot_trunc;
  logic                               ch_valid;
  logic                               ch_ready;
  lnfp_pkg::char_req_t                ch_req;

  assign in_ready   = (state_r == S_IDLE);
  assign quot_trunc = quot[lnfp_pkg::VALUE_WIDTH-1:0];

  lnfp_div_unit u_div (
    .clk   (clk),
    .hex   (hex_r),
    .num   (32'(num_r)),
    .quot  (quot),
    .digit (digit)
  );

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    rs_nxt    = rs_r;
    hex_nxt   = hex_r;
    num_nxt   = num_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    ch_valid  = 1'b0;
    ch_req    = '{ch: ch_r, rs: rs_r, last: 1'b1};
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_op)
            lnfp_pkg::OP_COMMAND: begin
              ch_nxt    = in_value[7:0];
              rs_nxt    = 1'b0;
              state_nxt = S_CHAR;
            end
            lnfp_pkg::OP_DATA: begin
              ch_nxt    = in_value[7:0];
              rs_nxt    = 1'b1;
              state_nxt = S_CHAR;
            end
            lnfp_pkg::OP_CURSOR: begin
              ch_nxt    = in_value[7:0] | lnfp_pkg::CURSOR_CMD;
              rs_nxt    = 1'b0;
              state_nxt = S_CHAR;
            end
            lnfp_pkg::OP_PRINT_DEC, lnfp_pkg::OP_PRINT_HEX: begin
              num_nxt   = in_value[lnfp_pkg::VALUE_WIDTH-1:0];
              hex_nxt   = (in_op == lnfp_pkg::OP_PRINT_HEX);
              cnt_nxt   = '0;
              state_nxt = S_DIV;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_CHAR: begin
        ch_valid = 1'b1;
        if (ch_ready) begin
          state_nxt = S_IDLE;
        end
      end
      // divide unit samples num_r here, result shows next cycle
      S_DIV: state_nxt = S_DIGIT;
      S_DIGIT: begin
        num_nxt = quot_trunc;
        cnt_nxt = cnt_r + 1'b1;
        if (quot_trunc == '0) begin
          idx_nxt   = cnt_r;
          state_nxt = S_RD;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_RD: state_nxt = S_SEND;
      S_SEND: begin
        ch_valid = 1'b1;
        ch_req   = '{ch: lnfp_pkg::digit_to_ascii(digit_r), rs: 1'b1,
                     last: (idx_r == '0)};
        if (ch_ready) begin
          if (idx_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r - 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      device_address_r <= lnfp_pkg::DEVICE_ADDRESS_RST;
      backlight_on_r   <= lnfp_pkg::BACKLIGHT_ON_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_we && cfg_index == lnfp_pkg::REG_DEVICE_ADDRESS) begin
        device_address_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == lnfp_pkg::REG_BACKLIGHT_ON) begin
        backlight_on_r <= cfg_wdata[0];
      end
    end
    ch_r  <= ch_nxt;
    rs_r  <= rs_nxt;
    hex_r <= hex_nxt;
    num_r <= num_nxt;
    cnt_r <= cnt_nxt;
    idx_r <= idx_nxt;
  end

  // digits are stored lowest first and read back highest first
  always_ff @(posedge clk) begin
    if (state_r == S_DIGIT) begin
      digit_mem[cnt_r] <= digit;
    end
    if (state_r == S_RD) begin
      digit_r <= digit_mem[idx_r];
    end
  end

  lnfp_framer u_framer (
    .clk            (clk),
    .rst_n          (rst_n),
    .device_address (device_address_r),
    .backlight_on   (backlight_on_r),
    .ch_valid       (ch_valid),
    .ch_ready       (ch_ready),
    .ch_req         (ch_req),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_is_address (out_is_address),
    .out_last       (out_last)
  );

endmodule
